// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the join engine RTL.
// No dependencies; simulation builds get the checks, SYNTH builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/eje_pkg.sv -----
// Types and constants of the equi-join engine.
// No dependencies; used by eje_cell and equi_join_engine.
package eje_pkg;

  localparam int KEY_W       = 64;
  localparam int OP_W        = 2;
  localparam int LEFT_ROW_W  = 16;
  localparam int RIGHT_ROW_W = 6;

  // Operation codes of an input beat
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  // Join modes
  localparam logic MODE_INNER = 1'b0;
  localparam logic MODE_OUTER = 1'b1;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take key and mark from the neighbor
    logic clr;    // drop the matched mark
  } cell_ctl_t;

endpackage

// ----- hdl/equi_join_engine.sv -----
// Equi-join engine top level: ring of key cells plus scan sequencer.
// Depends on eje_pkg, eje_cell and assert_macros.svh.
// A load or an unused op is done at accept; a probe or a flush goes through accept, one
// ring rotation and a finish step, and output stalls can hold the rotation and the finish.
// A pending result goes out as the next match leaves the head cell; the last goes out in
// the finish step. Synchronous reset empties the store, clears marks, left counter, join_mode.
`include "assert_macros.svh"
module equi_join_engine
  import eje_pkg::*;
#(
  parameter int RIGHT_ROWS    = 64,
  parameter int LEFT_ROW_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_op,
  input  logic [KEY_W-1:0]       in_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LEFT_ROW_W-1:0]  out_left_row,
  output logic                   out_left_null,
  output logic [RIGHT_ROW_W-1:0] out_right_row,
  output logic                   out_right_null,
  output logic                   out_last
);

  localparam int IDX_W = $clog2(RIGHT_ROWS);
  localparam int CNT_W = $clog2(RIGHT_ROWS + 1);
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(RIGHT_ROWS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t                   state_r;
  logic                     mode_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [LEFT_ROW_BITS-1:0] left_cnt_r;
  logic [LEFT_ROW_BITS-1:0] lrow_r;
  logic [OP_W-1:0]          op_r;
  logic [KEY_W-1:0]         key_r;
  logic [IDX_W-1:0]         pos_r;
  logic                     pend_v_r;
  logic [IDX_W-1:0]         pend_row_r;
  logic                     out_valid_r;
  logic [LEFT_ROW_W-1:0]    out_left_row_r;
  logic                     out_left_null_r;
  logic [RIGHT_ROW_W-1:0]   out_right_row_r;
  logic                     out_right_null_r;
  logic                     out_last_r;

  logic [KEY_W-1:0] cell_key  [RIGHT_ROWS];
  logic             cell_mark [RIGHT_ROWS];
  cell_ctl_t        ctl;

  logic             in_acc;
  logic             in_range;
  logic             hit;
  logic             out_free;
  logic             advance;
  logic             push_scan;
  logic             fin_need_null;
  logic             fin_done;
  logic             out_load;
  logic [31:0]      lrow_ext;
  logic [LEFT_ROW_W-1:0] lrow_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  // Judge the row at the head cell
  assign in_range = CNT_W'(pos_r) < cnt_r;
  always_comb begin
    if (op_r == OP_PROBE) begin
      hit = in_range && (cell_key[0] == key_r);
    end else begin
      hit = in_range && !cell_mark[0] && (mode_r == MODE_OUTER);
    end
  end

  // Step the scan unless a second hit finds the output register busy
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = (state_r == S_SCAN) && (!(hit && pend_v_r) || out_free);
  assign push_scan = advance && hit && pend_v_r;

  assign fin_need_null = (op_r == OP_PROBE) && (mode_r == MODE_OUTER) && !pend_v_r;
  assign fin_done      = (state_r == S_FIN) && (out_free || !(pend_v_r || fin_need_null));

  // Output register takes a new beat this cycle
  assign out_load = push_scan || (fin_done && (pend_v_r || fin_need_null));

  assign lrow_ext = 32'(lrow_r);
  assign lrow_out = lrow_ext[LEFT_ROW_W-1:0];

  assign ctl.shift = advance;
  assign ctl.clr   = fin_done && (op_r == OP_FLUSH);

  // Ring of cells: each shifts toward the head, the head wraps to the tail
  for (genvar g = 0; g < RIGHT_ROWS; g++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    logic             nbr_mark;
    logic             load_en;
    if (g == RIGHT_ROWS - 1) begin : g_tail
      assign nbr_key  = cell_key[0];
      assign nbr_mark = cell_mark[0] || (hit && (op_r == OP_PROBE));
    end else begin : g_body
      assign nbr_key  = cell_key[g+1];
      assign nbr_mark = cell_mark[g+1];
    end
    assign load_en = in_acc && (in_op == OP_LOAD) && (cnt_r == CNT_W'(g));
    eje_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load_en  (load_en),
      .load_key (in_key),
      .nbr_key  (nbr_key),
      .nbr_mark (nbr_mark),
      .key      (cell_key[g]),
      .mark     (cell_mark[g])
    );
  end

  // Hold item context; the key needs no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= in_key;
      lrow_r <= left_cnt_r;
    end
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_INNER;
      cnt_r       <= '0;
      left_cnt_r  <= '0;
      op_r        <= OP_LOAD;
      pos_r       <= '0;
      pend_v_r    <= 1'b0;
      pend_row_r  <= '0;
      out_valid_r <= 1'b0;
      out_left_row_r   <= '0;
      out_left_null_r  <= 1'b0;
      out_right_row_r  <= '0;
      out_right_null_r <= 1'b0;
      out_last_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r  <= in_op;
            pos_r <= '0;
            case (in_op)
              OP_LOAD: begin
                if (cnt_r < CNT_W'(RIGHT_ROWS)) begin
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              OP_PROBE: begin
                if (left_cnt_r != '1) begin
                  left_cnt_r <= left_cnt_r + 1'b1;
                end
                state_r <= S_SCAN;
              end
              OP_FLUSH: begin
                state_r <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (advance) begin
            pos_r <= pos_r + 1'b1;
            if (hit) begin
              pend_v_r   <= 1'b1;
              pend_row_r <= pos_r;
            end
            if (push_scan) begin
              out_valid_r      <= 1'b1;
              out_left_row_r   <= (op_r == OP_PROBE) ? lrow_out : '0;
              out_left_null_r  <= (op_r != OP_PROBE);
              out_right_row_r  <= RIGHT_ROW_W'(pend_row_r);
              out_right_null_r <= 1'b0;
              out_last_r       <= 1'b0;
            end
            if (pos_r == POS_LAST) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (fin_done) begin
            if (pend_v_r || fin_need_null) begin
              out_valid_r      <= 1'b1;
              out_left_row_r   <= (op_r == OP_PROBE) ? lrow_out : '0;
              out_left_null_r  <= (op_r != OP_PROBE);
              out_right_row_r  <= pend_v_r ? RIGHT_ROW_W'(pend_row_r) : '0;
              out_right_null_r <= !pend_v_r;
              out_last_r       <= 1'b1;
            end
            pend_v_r <= 1'b0;
            if (op_r == OP_FLUSH) begin
              cnt_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_row   = out_left_row_r;
  assign out_left_null  = out_left_null_r;
  assign out_right_row  = out_right_row_r;
  assign out_right_null = out_right_null_r;
  assign out_last       = out_last_r;

  // Checks on the sequencer
  `ASSERT_PROP(a_idle_no_pend, clk, rst_n, in_ready |-> !pend_v_r)
  `ASSERT_PROP(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(RIGHT_ROWS))
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, (state_r == S_SCAN) && !advance, $stable(pos_r))
  `ASSERT_NEXT(a_wrap_fin, clk, rst_n, advance && (pos_r == POS_LAST), state_r == S_FIN)

endmodule

// ----- hdl/eje_cell.sv -----
// One storage cell of the join ring: a right-table key and its matched mark.
// Depends on eje_pkg.
module eje_cell
  import eje_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             load_en,
  input  logic [KEY_W-1:0] load_key,
  input  logic [KEY_W-1:0] nbr_key,
  input  logic             nbr_mark,
  output logic [KEY_W-1:0] key,
  output logic             mark
);

  logic [KEY_W-1:0] key_r;
  logic             mark_r;

  // Hold the key; shift it along the ring or take a new load
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r <= nbr_key;
    end else if (load_en) begin
      key_r <= load_key;
    end
  end

  // Track the matched mark; a load or a flush clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else if (ctl.shift) begin
      mark_r <= nbr_mark;
    end else if (load_en || ctl.clr) begin
      mark_r <= 1'b0;
    end
  end

  assign key  = key_r;
  assign mark = mark_r;

endmodule
